// ----- rtl/mta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types, widths and codes of the mesh tangent accumulator.
// ----------------------------------------------------------------------------
package mta_pkg;

  // Vertex store geometry.
  localparam int unsigned NUM_VERTICES = 1024;
  localparam int unsigned VTX_AW       = $clog2(NUM_VERTICES);

  // Field and datapath widths.
  localparam int unsigned COORD_W = 16;   // position and UV components
  localparam int unsigned SUM_W   = 20;   // tangent sum components
  localparam int unsigned TAN_W   = 16;   // Q1.14 tangent components
  localparam int unsigned VEC_W   = 36;   // signed vector into the normaliser
  localparam int unsigned MAG_W   = 35;   // magnitude of that vector
  localparam int unsigned SQ_W    = 50;   // sum of three squared 24 bit values
  localparam int unsigned ROOT_W  = 26;   // integer square root of that sum
  localparam int unsigned NUM_W   = 40;   // dividend and shifted divisor
  localparam int unsigned QUO_W   = 15;   // quotient, at most one in Q1.14

  localparam logic [QUO_W-1:0]  UNIT_Q14 = 15'd16384;
  localparam logic [SUM_W-1:0]  SUM_MAX  = 20'h7FFFF;
  localparam logic [SUM_W-1:0]  SUM_MIN  = 20'h80000;

  // Operation selector carried in the input tuser.
  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_TRI  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  // Result status carried in the output tuser.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DEGEN = 2'd1,
    STAT_ZERO  = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  typedef logic signed [VEC_W-1:0] vec_t;

  // One vertex entry, x in the lowest bits.
  typedef struct packed {
    logic signed [COORD_W-1:0] v;
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  // One tangent sum entry, x in the lowest bits.
  typedef struct packed {
    logic signed [SUM_W-1:0] z;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] x;
  } sum_t;

  // Status and result of the normaliser towards the sequencer.
  typedef struct packed {
    logic                        done;
    logic                        zero;
    logic [2:0][TAN_W-1:0]       res;
  } norm_res_t;

endpackage

// ----- rtl/mesh_tangent_accumulator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_tangent_accumulator_core
// Per-vertex tangent generation from UVs over a vertex memory and a tangent
// sum memory, with load, add-triangle and read operations.
// ----------------------------------------------------------------------------
// One operation is handled at a time and each gives exactly one output beat.
// After reset the block clears the whole tangent sum memory and takes no
// input beat until that is done. A load writes the vertex store and then
// finishes, and an unused operation goes straight to the finishing state.
// A read and a triangle are set mostly by the normaliser, whose square root
// resolves one bit per cycle and whose divider produces one quotient bit per
// cycle for each component; a triangle adds three vertex reads, eight
// multiplies on one multiplier and three read-modify-writes of the sum
// memory. A read of a zero sum or a triangle with a zero tangent skips the
// divider, and a triangle with a zero UV determinant skips the normaliser.
// A new input beat is taken while an earlier result still waits on the
// output.
module mesh_tangent_accumulator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Fields from bit 0: vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
  // corner_a, corner_b, corner_c.
  input  logic [119:0] s_axis_tdata,
  // Fields from bit 0: func.
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: tangent_x, tangent_y, tangent_z.
  output logic [47:0]  m_axis_tdata,
  // Fields from bit 0: status.
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready
);

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_LOAD   = 15'b000000000000100,
    S_VRD    = 15'b000000000001000,
    S_EDGE   = 15'b000000000010000,
    S_MUL    = 15'b000000000100000,
    S_TSUB   = 15'b000000001000000,
    S_TSIGN  = 15'b000000010000000,
    S_SRD    = 15'b000000100000000,
    S_SCAP   = 15'b000001000000000,
    S_NSTART = 15'b000010000000000,
    S_NORM   = 15'b000100000000000,
    S_URD    = 15'b001000000000000,
    S_UWR    = 15'b010000000000000,
    S_FIN    = 15'b100000000000000
  } state_e;

  localparam int unsigned AW = mta_pkg::VTX_AW;

  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q;

  // Captured input beat.
  mta_pkg::func_e   func_q;
  logic [AW-1:0]    vidx_q;
  mta_pkg::vertex_t vtx_in_q;
  logic [AW-1:0]    corner_q [3];

  // Triangle datapath.
  mta_pkg::vertex_t          va_q, vb_q, vc_q;
  logic signed [16:0]        e1_q [3];
  logic signed [16:0]        e2_q [3];
  logic signed [16:0]        d1u_q, d1v_q, d2u_q, d2v_q;
  logic signed [33:0]        prod_q [8];
  logic                      det_zero_q, det_neg_q;
  mta_pkg::vec_t             vec_q [3];
  logic [2:0][mta_pkg::TAN_W-1:0] tan_q;
  logic                      sat_q;

  // Pending and registered result.
  logic [47:0]               pend_tan_q;
  mta_pkg::status_e          pend_stat_q;
  logic                      m_valid_q;
  logic [47:0]               m_data_q;
  mta_pkg::status_e          m_stat_q;

  // Memories.
  mta_pkg::vertex_t vtx_mem [mta_pkg::NUM_VERTICES];
  mta_pkg::sum_t    sum_mem [mta_pkg::NUM_VERTICES];
  mta_pkg::vertex_t vtx_rd_q;
  mta_pkg::sum_t    sum_rd_q;
  logic [AW-1:0]    vtx_raddr;
  logic [AW-1:0]    sum_raddr;
  logic             sum_we;
  logic [AW-1:0]    sum_waddr;
  mta_pkg::sum_t    sum_wdata;

  logic signed [16:0]  mul_a, mul_b;
  logic signed [33:0]  mul_p;
  logic [34:0]         det;
  logic [34:0]         tdiff [3];
  logic [1:0]          csel;
  logic                in_acc;
  logic                out_free;
  logic                upd_sat;
  mta_pkg::sum_t       upd_sum;
  mta_pkg::norm_res_t  norm;

  // Difference of two 16 bit values with one guard bit.
  function automatic logic signed [16:0] sub17(
    input logic signed [15:0] a,
    input logic signed [15:0] b
  );
    return {a[15], a} - {b[15], b};
  endfunction

  // Saturating add of a Q1.14 component to a sum; bit 20 flags a clamp.
  function automatic logic [mta_pkg::SUM_W:0] sat_add(
    input logic [mta_pkg::SUM_W-1:0] acc,
    input logic [mta_pkg::TAN_W-1:0] inc
  );
    logic [mta_pkg::SUM_W:0] s;
    logic                    ovf;
    s   = {acc[mta_pkg::SUM_W-1], acc} + {{5{inc[mta_pkg::TAN_W-1]}}, inc};
    ovf = s[mta_pkg::SUM_W] ^ s[mta_pkg::SUM_W-1];
    if (!ovf) return {1'b0, s[mta_pkg::SUM_W-1:0]};
    return {1'b1, s[mta_pkg::SUM_W] ? mta_pkg::SUM_MIN : mta_pkg::SUM_MAX};
  endfunction

  mta_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_NSTART),
    .vec_i   (vec_q),
    .res_o   (norm)
  );

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign csel     = (cnt_q[1:0] == 2'd3) ? 2'd2 : cnt_q[1:0];

  // Shared multiplier operands for the determinant and tangent products.
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    begin mul_a = d1u_q; mul_b = d2v_q;   end
      3'd1:    begin mul_a = d2u_q; mul_b = d1v_q;   end
      3'd2:    begin mul_a = d2v_q; mul_b = e1_q[0]; end
      3'd3:    begin mul_a = d1v_q; mul_b = e2_q[0]; end
      3'd4:    begin mul_a = d2v_q; mul_b = e1_q[1]; end
      3'd5:    begin mul_a = d1v_q; mul_b = e2_q[1]; end
      3'd6:    begin mul_a = d2v_q; mul_b = e1_q[2]; end
      default: begin mul_a = d1v_q; mul_b = e2_q[2]; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Determinant and tangent differences from the registered products.
  always_comb begin
    det = {prod_q[0][33], prod_q[0]} - {prod_q[1][33], prod_q[1]};
    for (int i = 0; i < 3; i++) begin
      tdiff[i] = {prod_q[2+2*i][33], prod_q[2+2*i]} - {prod_q[3+2*i][33], prod_q[3+2*i]};
    end
  end

  // Saturating update of one sum entry.
  always_comb begin
    logic [mta_pkg::SUM_W:0] rx, ry, rz;
    rx = sat_add(sum_rd_q.x, tan_q[0]);
    ry = sat_add(sum_rd_q.y, tan_q[1]);
    rz = sat_add(sum_rd_q.z, tan_q[2]);
    upd_sum.x = rx[mta_pkg::SUM_W-1:0];
    upd_sum.y = ry[mta_pkg::SUM_W-1:0];
    upd_sum.z = rz[mta_pkg::SUM_W-1:0];
    upd_sat   = rx[mta_pkg::SUM_W] | ry[mta_pkg::SUM_W] | rz[mta_pkg::SUM_W];
  end

  // Memory address and write selection. Each corner update reads, then
  // writes in the following cycle before the next read, so a repeated
  // corner always sees the previous write.
  always_comb begin
    vtx_raddr = corner_q[csel];
    sum_raddr = (state_q == S_SRD) ? vidx_q : corner_q[csel];
    sum_we    = 1'b0;
    sum_waddr = cnt_q;
    sum_wdata = '0;
    case (state_q)
      S_CLEAR: sum_we = 1'b1;
      S_LOAD: begin
        sum_we    = 1'b1;
        sum_waddr = vidx_q;
      end
      S_UWR: begin
        sum_we    = 1'b1;
        sum_waddr = corner_q[csel];
        sum_wdata = upd_sum;
      end
      default: begin
      end
    endcase
  end

  // Vertex memory.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) vtx_mem[vidx_q] <= vtx_in_q;
    vtx_rd_q <= vtx_mem[vtx_raddr];
  end

  // Tangent sum memory.
  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rd_q <= sum_mem[sum_raddr];
  end

  // Operation sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (cnt_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            mta_pkg::FUNC_LOAD: state_d = S_LOAD;
            mta_pkg::FUNC_TRI:  state_d = S_VRD;
            mta_pkg::FUNC_READ: state_d = S_SRD;
            default:            state_d = S_FIN;
          endcase
        end
      end
      S_LOAD:   state_d = S_FIN;
      S_VRD:    if (cnt_q[1:0] == 2'd3) state_d = S_EDGE;
      S_EDGE:   state_d = S_MUL;
      S_MUL:    if (cnt_q[2:0] == 3'd7) state_d = S_TSUB;
      S_TSUB:   state_d = S_TSIGN;
      S_TSIGN:  state_d = det_zero_q ? S_FIN : S_NSTART;
      S_SRD:    state_d = S_SCAP;
      S_SCAP:   state_d = S_NSTART;
      S_NSTART: state_d = S_NORM;
      S_NORM: begin
        if (norm.done) begin
          state_d = (func_q == mta_pkg::FUNC_TRI && !norm.zero) ? S_URD : S_FIN;
        end
      end
      S_URD:    state_d = S_UWR;
      S_UWR:    state_d = (cnt_q[1:0] == 2'd2) ? S_FIN : S_URD;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR, S_VRD, S_MUL, S_UWR: cnt_q <= cnt_q + 1'b1;
        S_URD:                        cnt_q <= cnt_q;
        default:                      cnt_q <= '0;
      endcase
      if (state_q == S_FIN && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_q      <= mta_pkg::func_e'(s_axis_tuser);
          vidx_q      <= s_axis_tdata[9:0];
          vtx_in_q    <= s_axis_tdata[89:10];
          corner_q[0] <= s_axis_tdata[99:90];
          corner_q[1] <= s_axis_tdata[109:100];
          corner_q[2] <= s_axis_tdata[119:110];
          pend_tan_q  <= '0;
          pend_stat_q <= mta_pkg::STAT_OK;
          sat_q       <= 1'b0;
        end
      end
      S_VRD: begin
        case (cnt_q[1:0])
          2'd1:    va_q <= vtx_rd_q;
          2'd2:    vb_q <= vtx_rd_q;
          2'd3:    vc_q <= vtx_rd_q;
          default: begin
          end
        endcase
      end
      S_EDGE: begin
        e1_q[0] <= sub17(vb_q.x, va_q.x);
        e1_q[1] <= sub17(vb_q.y, va_q.y);
        e1_q[2] <= sub17(vb_q.z, va_q.z);
        e2_q[0] <= sub17(vc_q.x, va_q.x);
        e2_q[1] <= sub17(vc_q.y, va_q.y);
        e2_q[2] <= sub17(vc_q.z, va_q.z);
        d1u_q   <= sub17(vb_q.u, va_q.u);
        d1v_q   <= sub17(vb_q.v, va_q.v);
        d2u_q   <= sub17(vc_q.u, va_q.u);
        d2v_q   <= sub17(vc_q.v, va_q.v);
      end
      S_MUL: prod_q[cnt_q[2:0]] <= mul_p;
      S_TSUB: begin
        det_zero_q <= (det == '0);
        det_neg_q  <= det[34];
        for (int i = 0; i < 3; i++) vec_q[i] <= {tdiff[i][34], tdiff[i]};
      end
      S_TSIGN: begin
        // Only the sign of the determinant matters after normalisation.
        if (det_zero_q) begin
          pend_stat_q <= mta_pkg::STAT_DEGEN;
        end else if (det_neg_q) begin
          for (int i = 0; i < 3; i++) vec_q[i] <= -vec_q[i];
        end
      end
      S_SCAP: begin
        // Sign-extend the stored sums into the normaliser input.
        vec_q[0] <= {{(mta_pkg::VEC_W-mta_pkg::SUM_W){sum_rd_q.x[mta_pkg::SUM_W-1]}},
                     sum_rd_q.x};
        vec_q[1] <= {{(mta_pkg::VEC_W-mta_pkg::SUM_W){sum_rd_q.y[mta_pkg::SUM_W-1]}},
                     sum_rd_q.y};
        vec_q[2] <= {{(mta_pkg::VEC_W-mta_pkg::SUM_W){sum_rd_q.z[mta_pkg::SUM_W-1]}},
                     sum_rd_q.z};
      end
      S_NORM: begin
        if (norm.done) begin
          tan_q <= norm.res;
          if (func_q == mta_pkg::FUNC_READ) begin
            if (norm.zero) pend_stat_q <= mta_pkg::STAT_ZERO;
            else           pend_tan_q  <= norm.res;
          end else if (norm.zero) begin
            pend_stat_q <= mta_pkg::STAT_DEGEN;
          end
        end
      end
      S_UWR: begin
        if (upd_sat) sat_q <= 1'b1;
        if (cnt_q[1:0] == 2'd2 && (sat_q || upd_sat)) pend_stat_q <= mta_pkg::STAT_SAT;
      end
      S_FIN: begin
        if (out_free) begin
          m_data_q <= pend_tan_q;
          m_stat_q <= pend_stat_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_stat_q;

`ifndef ASSERT_OFF
  // The normaliser only finishes while the sequencer waits for it.
  a_norm_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm.done |-> state_q == S_NORM)
    else $error("normaliser finished outside its wait state");

  // A new output beat is only raised from the finishing state.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_FIN))
    else $error("output beat raised outside the finishing state");

  // Only a successful read carries a tangent.
  a_tan_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_stat_q != mta_pkg::STAT_OK) |-> m_data_q == '0)
    else $error("non-zero tangent with a failure status");
`endif

endmodule

// ----- rtl/mta_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mta_norm
// Multi-cycle normaliser: scales a three component vector to unit length in
// Q1.14 with a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module mta_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mta_pkg::vec_t       vec_i [3],
  output mta_pkg::norm_res_t  res_o
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_e;

  nstate_e state_q, state_d;

  logic [mta_pkg::MAG_W-1:0]  mag_q [3];
  logic [2:0]                 neg_q;
  logic [1:0]                 k_q;
  logic [3:0]                 j_q;
  logic [47:0]                prod_q;
  logic [mta_pkg::SQ_W-1:0]   n_q;
  logic [mta_pkg::SQ_W-1:0]   root_q;
  logic [mta_pkg::SQ_W-1:0]   bit_q;
  logic [mta_pkg::NUM_W-1:0]  num_q;
  logic [mta_pkg::NUM_W-1:0]  dvs_q;
  logic [mta_pkg::QUO_W-1:0]  quo_q;
  logic [2:0][mta_pkg::TAN_W-1:0] res_q;
  logic                       zero_q;

  logic [mta_pkg::VEC_W-1:0]  vec_abs [3];
  logic                       big;
  logic [1:0]                 k_sel;
  logic [1:0]                 k_nxt;
  logic [23:0]                sq_op;
  logic [mta_pkg::SQ_W-1:0]   sqrt_try;
  logic                       sqrt_ge;
  logic [mta_pkg::SQ_W-1:0]   root_next;
  logic [mta_pkg::ROOT_W-1:0] m_next;
  logic [mta_pkg::ROOT_W-1:0] m_cur;
  logic                       div_ge;
  logic [mta_pkg::QUO_W-1:0]  quo_next;
  logic [mta_pkg::QUO_W-1:0]  quo_clamp;
  logic [mta_pkg::TAN_W-1:0]  quo_ext;

  // Dividend for one component: magnitude in Q1.14 plus half the root for rounding.
  function automatic logic [mta_pkg::NUM_W-1:0] num_init(
    input logic [23:0]                mag,
    input logic [mta_pkg::ROOT_W-1:0] m
  );
    logic [mta_pkg::NUM_W-1:0] a;
    logic [mta_pkg::NUM_W-1:0] b;
    a = {2'b00, mag, 14'b0};
    b = mta_pkg::NUM_W'(m >> 1);
    return a + b;
  endfunction

  // Absolute values, shift detection and per-step arithmetic.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec_abs[i] = vec_i[i][mta_pkg::VEC_W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
    big = (|mag_q[0][mta_pkg::MAG_W-1:24]) | (|mag_q[1][mta_pkg::MAG_W-1:24]) |
          (|mag_q[2][mta_pkg::MAG_W-1:24]);
    k_sel     = (k_q == 2'd3) ? 2'd2 : k_q;
    k_nxt     = (k_q >= 2'd2) ? 2'd2 : k_q + 2'd1;
    sq_op     = mag_q[k_sel][23:0];
    sqrt_try  = root_q + bit_q;
    sqrt_ge   = n_q >= sqrt_try;
    root_next = sqrt_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
    m_next    = root_next[mta_pkg::ROOT_W-1:0];
    m_cur     = root_q[mta_pkg::ROOT_W-1:0];
    div_ge    = num_q >= dvs_q;
    quo_next  = {quo_q[mta_pkg::QUO_W-2:0], div_ge};
    quo_clamp = (quo_next > mta_pkg::UNIT_Q14) ? mta_pkg::UNIT_Q14 : quo_next;
    quo_ext   = {1'b0, quo_clamp};
  end

  // Sequencing of the normalisation steps.
  always_comb begin
    state_d = state_q;
    case (state_q)
      N_IDLE:  if (start_i) state_d = N_SHIFT;
      N_SHIFT: if (!big) state_d = N_SQ;
      N_SQ:    if (k_q == 2'd3) state_d = N_SQRT;
      N_SQRT: begin
        if (bit_q[0]) state_d = (m_next == '0) ? N_DONE : N_DIV;
      end
      N_DIV: begin
        if (j_q == 4'(mta_pkg::QUO_W - 1) && k_q == 2'd2) state_d = N_DONE;
      end
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= vec_abs[i][mta_pkg::MAG_W-1:0];
            neg_q[i] <= vec_i[i][mta_pkg::VEC_W-1];
          end
          k_q <= 2'd0;
          n_q <= '0;
        end
      end
      N_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end
      end
      N_SQ: begin
        // Square one magnitude a cycle, accumulate it the cycle after.
        if (k_q != 2'd3) prod_q <= sq_op * sq_op;
        if (k_q != 2'd0) n_q <= n_q + mta_pkg::SQ_W'(prod_q);
        k_q    <= k_q + 2'd1;
        root_q <= '0;
        bit_q  <= mta_pkg::SQ_W'(1) << (mta_pkg::SQ_W - 2);
      end
      N_SQRT: begin
        if (sqrt_ge) n_q <= n_q - sqrt_try;
        root_q <= root_next;
        bit_q  <= bit_q >> 2;
        if (bit_q[0]) begin
          zero_q <= (m_next == '0);
          num_q  <= num_init(mag_q[0][23:0], m_next);
          dvs_q  <= mta_pkg::NUM_W'(m_next) << 14;
          quo_q  <= '0;
          j_q    <= '0;
          k_q    <= 2'd0;
        end
      end
      N_DIV: begin
        // Restoring division, one quotient bit a cycle; the last bit closes
        // the component and loads the dividend of the next one.
        if (j_q == 4'(mta_pkg::QUO_W - 1)) begin
          res_q[k_sel] <= neg_q[k_sel] ? (~quo_ext + 1'b1) : quo_ext;
          j_q   <= '0;
          quo_q <= '0;
          k_q   <= k_nxt;
          num_q <= num_init(mag_q[k_nxt][23:0], m_cur);
          dvs_q <= mta_pkg::NUM_W'(m_cur) << 14;
        end else begin
          if (div_ge) num_q <= num_q - dvs_q;
          dvs_q <= dvs_q >> 1;
          quo_q <= quo_next;
          j_q   <= j_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.done = (state_q == N_DONE);
  assign res_o.zero = zero_q;
  assign res_o.res  = res_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the mesh tangent accumulator core. Loads,
// triangle additions and reads are driven with random gaps on the input
// stream and random back-pressure on the output stream. A behavioural
// predictor of the vertex store, the tangent sums and the normaliser
// computes each expected beat, which is compared field by field with the
// beats leaving the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NV = 1024;
  localparam int SUM_HI = 524287;
  localparam int SUM_LO = -524288;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    mta_pkg::func_e func;
    bit [9:0] vidx;
    bit [15:0] px, py, pz, tu, tv;
    bit [9:0] ca, cb, cc;
  } op_t;

  typedef struct {
    bit [15:0] tx, ty, tz;
    mta_pkg::status_e st;
  } tangent_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;

  mesh_tangent_accumulator_core i_dut (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state.
  longint pos_mem [NV][3];
  longint uv_mem [NV][2];
  longint sum_mem [NV][3];
  bit     loaded [NV];

  op_t           pending_ops[$];
  tangent_beat_t expected_beats[$];
  int            n_errors = 0;
  int            n_beats = 0;
  int            stat_seen [4];
  bit            stim_done = 1'b0;

  function automatic longint isqrt(longint unsigned n);
    longint unsigned root = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Scale a vector to unit length in Q1.14; returns 0 for a zero vector.
  function automatic bit unit_vector(input longint v[3], output longint r[3]);
    longint unsigned mg[3], big = 0, sq = 0, m, q;
    int s = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = v[i] < 0 ? -v[i] : v[i];
      if (mg[i] > big) big = mg[i];
    end
    while (s < 63 && (big >> s) >= (64'd1 << 24)) s++;
    for (int i = 0; i < 3; i++) begin
      mg[i] >>= s;
      sq += mg[i] * mg[i];
    end
    m = isqrt(sq);
    for (int i = 0; i < 3; i++) r[i] = 0;
    if (m == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = (mg[i] * 16384 + m / 2) / m;
      if (q > 16384) q = 16384;
      r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic mta_pkg::status_e accumulate_triangle(int a, int b, int c);
    longint e1[3], e2[3], t[3], n[3], d1u, d1v, d2u, d2v, det, r;
    int k3[3];
    bit sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = pos_mem[b][i] - pos_mem[a][i];
      e2[i] = pos_mem[c][i] - pos_mem[a][i];
    end
    d1u = uv_mem[b][0] - uv_mem[a][0];
    d1v = uv_mem[b][1] - uv_mem[a][1];
    d2u = uv_mem[c][0] - uv_mem[a][0];
    d2v = uv_mem[c][1] - uv_mem[a][1];
    det = d1u * d2v - d2u * d1v;
    if (det == 0) return mta_pkg::STAT_DEGEN;
    for (int i = 0; i < 3; i++) begin
      t[i] = d2v * e1[i] - d1v * e2[i];
      if (det < 0) t[i] = -t[i];
    end
    if (!unit_vector(t, n)) return mta_pkg::STAT_DEGEN;
    k3[0] = a; k3[1] = b; k3[2] = c;
    foreach (k3[k]) begin
      for (int i = 0; i < 3; i++) begin
        r = sum_mem[k3[k]][i] + n[i];
        if (r > SUM_HI) begin r = SUM_HI; sat = 1'b1; end
        if (r < SUM_LO) begin r = SUM_LO; sat = 1'b1; end
        sum_mem[k3[k]][i] = r;
      end
    end
    return sat ? mta_pkg::STAT_SAT : mta_pkg::STAT_OK;
  endfunction

  // Advance the predictor by one operation and queue its expected beat.
  function automatic void predict_tangent(op_t op);
    tangent_beat_t eb;
    longint v[3], r[3];
    eb.tx = 0; eb.ty = 0; eb.tz = 0; eb.st = mta_pkg::STAT_OK;
    case (op.func)
      mta_pkg::FUNC_LOAD: begin
        pos_mem[op.vidx][0] = $signed(op.px);
        pos_mem[op.vidx][1] = $signed(op.py);
        pos_mem[op.vidx][2] = $signed(op.pz);
        uv_mem[op.vidx][0] = $signed(op.tu);
        uv_mem[op.vidx][1] = $signed(op.tv);
        for (int i = 0; i < 3; i++) sum_mem[op.vidx][i] = 0;
      end
      mta_pkg::FUNC_TRI: eb.st = accumulate_triangle(op.ca, op.cb, op.cc);
      mta_pkg::FUNC_READ: begin
        for (int i = 0; i < 3; i++) v[i] = sum_mem[op.vidx][i];
        if (unit_vector(v, r)) begin
          eb.tx = r[0]; eb.ty = r[1]; eb.tz = r[2];
        end else begin
          eb.st = mta_pkg::STAT_ZERO;
        end
      end
      default: ;
    endcase
    expected_beats.push_back(eb);
  endfunction

  // Stimulus helpers; only vertices already loaded are read or used.
  function automatic void push_load(int idx, bit [15:0] px, bit [15:0] py, bit [15:0] pz,
                                    bit [15:0] tu, bit [15:0] tv);
    op_t op = '{func: mta_pkg::FUNC_LOAD, default: 0};
    op.vidx = idx;
    op.px = px; op.py = py; op.pz = pz; op.tu = tu; op.tv = tv;
    op.ca = $urandom; op.cb = $urandom; op.cc = $urandom;
    loaded[idx] = 1'b1;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_tri(int a, int b, int c);
    op_t op = '{func: mta_pkg::FUNC_TRI, default: 0};
    op.ca = a; op.cb = b; op.cc = c;
    op.vidx = $urandom; op.px = $urandom; op.tv = $urandom;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_read(int idx);
    op_t op = '{func: mta_pkg::FUNC_READ, default: 0};
    op.vidx = idx; op.pz = $urandom;
    pending_ops.push_back(op);
  endfunction

  function automatic int pick_loaded(int lo, int hi);
    int k;
    do k = $urandom_range(hi, lo); while (!loaded[k]);
    return k;
  endfunction

  // Stimulus generation.
  initial begin
    op_t op;
    int a, b, c, base;
    // Directed part: extremes, degenerate, saturation, zero read, unused code.
    push_load(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_load(1, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    push_load(2, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
    push_load(1023, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_read(0);
    push_tri(0, 1, 2);
    push_read(0);
    push_read(1023);
    push_tri(0, 0, 0);
    push_tri(0, 1, 1);
    push_tri(1023, 1, 2);
    push_load(3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_tri(0, 3, 1023);
    push_read(3);
    for (int i = 0; i < 40; i++) push_tri(0, 1, 2);
    push_read(0);
    push_read(2);
    op = '{func: mta_pkg::FUNC_NONE, default: 0};
    op.vidx = '1; op.px = '1; op.ca = '1; op.cb = '1; op.cc = '1;
    pending_ops.push_back(op);
    push_load(0, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_read(0);
    // Random part: mostly small meshes loaded then stitched into triangles.
    while (pending_ops.size() < 1100) begin
      base = $urandom_range(1020, 0);
      for (int i = 0; i < 3; i++)
        push_load(base + i, $urandom, $urandom, $urandom, $urandom, $urandom);
      repeat ($urandom_range(8, 1)) begin
        a = pick_loaded(0, 1023); b = pick_loaded(0, 1023); c = pick_loaded(0, 1023);
        if ($urandom_range(3, 0) != 0) begin
          a = base; b = base + 1; c = base + 2;
        end
        push_tri(a, b, c);
      end
      repeat ($urandom_range(3, 1)) push_read(pick_loaded(0, 1023));
      if ($urandom_range(9, 0) == 0) begin
        op = '{func: mta_pkg::FUNC_NONE, default: 0};
        op.vidx = $urandom; op.ca = $urandom;
        pending_ops.push_back(op);
      end
    end
  end

  // Reset and cycle limit.
  longint cycle_count = 0;
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mesh_tangent_accumulator_core regression: fail");
      $finish;
    end
  end

  // Input acceptance: a beat is taken at the rising edge.
  bit in_taken = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_tangent(pending_ops.pop_front());
      in_taken = 1'b1;
    end
  end

  // Input driver: one beat per pending item, with a random gap before each.
  int  gap_left = 0;
  bit  gap_drawn = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (!gap_drawn) begin
        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(16, 0);
        gap_drawn = 1'b1;
      end
      if (gap_left > 0 || pending_ops.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
        if (pending_ops.size() == 0) stim_done = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_ops[0].func;
        s_axis_tdata  <= {pending_ops[0].cc, pending_ops[0].cb, pending_ops[0].ca,
                          pending_ops[0].tv, pending_ops[0].tu, pending_ops[0].pz,
                          pending_ops[0].py, pending_ops[0].px, pending_ops[0].vidx};
        gap_drawn = 1'b0;
      end
    end
  end

  // Output back-pressure, redrawn after each beat.
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compare each output beat against the oldest expectation.
  always @(posedge clk_i) begin
    tangent_beat_t eb;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      stall_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(16, 0);
      n_beats++;
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
        n_errors++;
      end else begin
        eb = expected_beats.pop_front();
        stat_seen[eb.st]++;
        if (m_axis_tdata[15:0] !== eb.tx) begin
          $error("tangent_x: expected %h, got %h", eb.tx, m_axis_tdata[15:0]);
          n_errors++;
        end
        if (m_axis_tdata[31:16] !== eb.ty) begin
          $error("tangent_y: expected %h, got %h", eb.ty, m_axis_tdata[31:16]);
          n_errors++;
        end
        if (m_axis_tdata[47:32] !== eb.tz) begin
          $error("tangent_z: expected %h, got %h", eb.tz, m_axis_tdata[47:32]);
          n_errors++;
        end
        if (m_axis_tuser !== eb.st) begin
          $error("status: expected %0d, got %0d", eb.st, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  // End of run.
  initial begin
    wait (stim_done && !s_axis_tvalid);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Checked %0d result beats: %0d ok, %0d degenerate, %0d zero, %0d saturated.",
             n_beats, stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3]);
    if (n_errors == 0) begin
      $display("mesh_tangent_accumulator_core regression: pass");
    end else begin
      $display("mesh_tangent_accumulator_core regression: fail");
    end
    $finish;
  end

endmodule
